>>> sv/mmn_pkg.sv
`default_nettype none

package mmn_pkg;

  localparam int MAX_ELEMENTS_DEF = 64;
  // Count width covers the whole parameter range (1..64) including the full count.
  localparam int CNT_W = 7;
  localparam int DATA_W = 32;
  // One quotient bit for the integer part plus sixteen fraction bits.
  localparam int QUO_W = 17;
  localparam int DIV_STEPS = QUO_W;
  localparam int STEP_W = 5;
  localparam int JOB_DEPTH = 2;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     passed_through;
    logic                     run_end;
  } result_t;

  typedef struct packed {
    logic                     bank;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] min_val;
    logic [DATA_W-1:0]        span;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FETCH,
    BK_LOAD,
    BK_DIV,
    BK_PUT
  } back_state_t;

endpackage

`default_nettype wire

>>> sv/mmn_store.sv
`default_nettype none

module mmn_store
  import mmn_pkg::*;
#(
  parameter int ADDR_W = 6
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [ADDR_W:0]          wr_addr,
  input  wire logic signed [DATA_W-1:0] wr_data,
  input  wire logic [ADDR_W:0]          rd_addr,
  output logic signed [DATA_W-1:0]      rd_data
);

  // Two banks: the loader fills one while the emitter drains the other.
  logic signed [DATA_W-1:0] mem [2**(ADDR_W+1)];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> sv/mmn_job_fifo.sv
`default_nettype none

module mmn_job_fifo
  import mmn_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire job_t wr_job,
  output logic      job_full,
  input  wire logic rd_en,
  output job_t      rd_job,
  output logic      job_empty
);

  job_t       slots [JOB_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] used;

  assign job_full  = (used == 2'(JOB_DEPTH));
  assign job_empty = (used == 2'd0);
  assign rd_job    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      if (wr_en && !rd_en) begin
        used <= used + 2'd1;
      end else if (rd_en && !wr_en) begin
        used <= used - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/mmn_front.sv
`default_nettype none

module mmn_front
  import mmn_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int ADDR_W = 6
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire in_item_t            item,
  input  wire logic                job_full,
  output logic                     wr_en,
  output logic [ADDR_W:0]          wr_addr,
  output logic signed [DATA_W-1:0] wr_data,
  output logic                     job_push,
  output job_t                     job
);

  localparam logic [CNT_W-1:0] MaxCount = CNT_W'(MAX_ELEMENTS);

  logic [CNT_W-1:0]         fill_count;
  logic signed [DATA_W-1:0] run_min;
  logic signed [DATA_W-1:0] run_max;
  logic                     bank;

  logic                     accept;
  logic                     has_room;
  logic                     first;
  logic signed [DATA_W-1:0] min_next;
  logic signed [DATA_W-1:0] max_next;
  logic [CNT_W-1:0]         count_next;

  assign accept   = push && !job_full;
  assign has_room = (fill_count < MaxCount);
  assign first    = (fill_count == '0);

  // Samples past capacity are dropped and leave min and max alone.
  always_comb begin
    min_next   = run_min;
    max_next   = run_max;
    count_next = fill_count;
    if (has_room) begin
      count_next = fill_count + CNT_W'(1);
      if (first || item.sample < run_min) begin
        min_next = item.sample;
      end
      if (first || item.sample > run_max) begin
        max_next = item.sample;
      end
    end
  end

  assign wr_en   = accept && has_room;
  assign wr_addr = {bank, fill_count[ADDR_W-1:0]};
  assign wr_data = item.sample;

  assign job_push    = accept && item.last;
  assign job.bank    = bank;
  assign job.count   = count_next;
  assign job.min_val = min_next;
  assign job.span    = DATA_W'(max_next - min_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      run_min    <= '0;
      run_max    <= '0;
      bank       <= 1'b0;
    end else if (accept) begin
      if (item.last) begin
        fill_count <= '0;
        run_min    <= '0;
        run_max    <= '0;
        bank       <= ~bank;
      end else begin
        fill_count <= count_next;
        run_min    <= min_next;
        run_max    <= max_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/mmn_back.sv
`default_nettype none

module mmn_back
  import mmn_pkg::*;
#(
  parameter int ADDR_W = 6
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     job_empty,
  input  wire job_t                     job,
  output logic                          job_pop,
  output logic [ADDR_W:0]               rd_addr,
  input  wire logic signed [DATA_W-1:0] rd_data,
  output logic                          empty,
  input  wire logic                     pop,
  output result_t                       result
);

  back_state_t       state;
  back_state_t       state_next;
  logic [CNT_W-1:0]  k;
  logic [DATA_W:0]   rem;
  logic [QUO_W-1:0]  quo;
  logic [STEP_W-1:0] step;
  logic              out_valid;
  result_t           hold;

  logic              passthru;
  logic [DATA_W-1:0] offset;
  logic [DATA_W:0]   trial;
  logic              fits;
  logic              div_done;
  logic              slot_free;
  logic              is_last;
  logic              put;

  assign passthru  = (job.span == '0);
  assign offset    = DATA_W'(rd_data - job.min_val);
  // The first step tests the offset itself; later steps shift in a zero bit.
  assign trial     = (step == '0) ? rem : {rem[DATA_W-1:0], 1'b0};
  assign fits      = (trial >= {1'b0, job.span});
  assign div_done  = (step == STEP_W'(DIV_STEPS - 1));
  assign slot_free = !out_valid || pop;
  assign is_last   = (k == job.count - CNT_W'(1));
  assign rd_addr   = {job.bank, k[ADDR_W-1:0]};

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!job_empty) begin
          state_next = BK_FETCH;
        end
      end
      BK_FETCH: state_next = BK_LOAD;
      BK_LOAD: begin
        state_next = passthru ? BK_PUT : BK_DIV;
      end
      BK_DIV: begin
        if (div_done) begin
          state_next = BK_PUT;
        end
      end
      BK_PUT: begin
        if (slot_free) begin
          state_next = is_last ? BK_IDLE : BK_FETCH;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    put     = (state == BK_PUT) && slot_free;
    job_pop = put && is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_IDLE) begin
        k <= '0;
      end else if (put) begin
        k <= k + CNT_W'(1);
      end
      if (put) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_LOAD: begin
        rem  <= {1'b0, offset};
        quo  <= '0;
        step <= '0;
        if (passthru) begin
          quo <= '0;
        end
      end
      BK_DIV: begin
        rem  <= fits ? (trial - {1'b0, job.span}) : trial;
        quo  <= {quo[QUO_W-2:0], fits};
        step <= step + STEP_W'(1);
      end
      default: begin
      end
    endcase
    if (put) begin
      hold.result_value   <= passthru ? rd_data : DATA_W'(quo);
      hold.passed_through <= passthru;
      hold.run_end        <= is_last;
    end
  end

  assign empty  = !out_valid;
  assign result = hold;

endmodule

`default_nettype wire

>>> sv/min_max_normalize_top.sv
// Results start once a frame's job reaches the back end. Each result goes through
// the fetch, load and put states, with the divide state before put unless min
// equals max (pass-through). Throughput: one input item per cycle while loading,
// unless full is high; one quotient bit per cycle (17-step divider); put waits while the previous result is unpopped.
// Two frame banks let the next frame load while the previous one drains.
// Synchronous active-high reset clears counters, queues and the result-valid flag, not the result contents.
`default_nettype none

module min_max_normalize_top
  import mmn_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t item,
  output logic          empty,
  input  wire logic     pop,
  output result_t       result
);

  localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  logic                     wr_en;
  logic [ADDR_W:0]          wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic [ADDR_W:0]          rd_addr;
  logic signed [DATA_W-1:0] rd_data;
  logic                     job_push;
  job_t                     job_in;
  logic                     job_full;
  logic                     job_pop;
  job_t                     job_head;
  logic                     job_empty;

  assign full = job_full;

  mmn_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .ADDR_W(ADDR_W)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .item(item),
    .job_full(job_full),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .job_push(job_push),
    .job(job_in)
  );

  mmn_store #(
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  mmn_job_fifo u_jobs (
    .clk(clk),
    .rst(rst),
    .wr_en(job_push),
    .wr_job(job_in),
    .job_full(job_full),
    .rd_en(job_pop),
    .rd_job(job_head),
    .job_empty(job_empty)
  );

  mmn_back #(
    .ADDR_W(ADDR_W)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .job_empty(job_empty),
    .job(job_head),
    .job_pop(job_pop),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .empty(empty),
    .pop(pop),
    .result(result)
  );

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
  import mmn_pkg::*;

  localparam int FRAME_CAP = 64;
  localparam int RANDOM_ITEMS = 160;
  localparam int TAIL_CYCLES = 100;
  localparam int CYCLE_LIMIT = 600000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     push = 1'b0;
  logic     full;
  in_item_t item = '0;
  logic     empty;
  logic     pop = 1'b0;
  result_t  result;

  min_max_normalize_top dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .item  (item),
    .empty (empty),
    .pop   (pop),
    .result(result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the frame being loaded.
  logic signed [31:0] frame_store [FRAME_CAP];
  logic signed [31:0] frame_lo = '0;
  logic signed [31:0] frame_hi = '0;
  int                 frame_fill = 0;

  result_t pending_results [$];
  int      error_count = 0;
  int      cycle_count = 0;

  // Sender pacing.
  bit gaps_on = 1'b0;
  int burst_left = 0;

  function automatic void emit_frame();
    longint lo64;
    longint hi64;
    longint span;
    longint off;
    longint quo;
    result_t r;
    for (int k = 0; k < frame_fill; k++) begin
      lo64 = frame_lo;
      hi64 = frame_hi;
      span = hi64 - lo64;
      r.run_end = (k == frame_fill - 1);
      if (span == 0) begin
        r.result_value = frame_store[k];
        r.passed_through = 1'b1;
      end else begin
        off = longint'(frame_store[k]) - lo64;
        quo = (off <<< 16) / span;
        r.result_value = quo[31:0];
        r.passed_through = 1'b0;
      end
      pending_results.push_back(r);
    end
    frame_fill = 0;
    frame_lo = '0;
    frame_hi = '0;
  endfunction

  function automatic void absorb_sample(in_item_t it);
    if (frame_fill < FRAME_CAP) begin
      if (frame_fill == 0) begin
        frame_lo = it.sample;
        frame_hi = it.sample;
      end else begin
        if (it.sample < frame_lo) frame_lo = it.sample;
        if (it.sample > frame_hi) frame_hi = it.sample;
      end
      frame_store[frame_fill] = it.sample;
      frame_fill++;
    end
    if (it.last) emit_frame();
  endfunction

  // All inputs change at the rising edge, so the values seen at the falling edge
  // are the ones that the next rising edge will act on.
  always @(negedge clk) begin
    result_t want;
    if (!rst && push && !full) absorb_sample(item);
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: value %0d passed %0b end %0b",
               result.result_value, result.passed_through, result.run_end);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.result_value !== want.result_value) begin
          $error("result_value: expected %0d, got %0d", want.result_value,
                 result.result_value);
          error_count++;
        end
        if (result.passed_through !== want.passed_through) begin
          $error("passed_through: expected %0b, got %0b", want.passed_through,
                 result.passed_through);
          error_count++;
        end
        if (result.run_end !== want.run_end) begin
          $error("run_end: expected %0b, got %0b", want.run_end, result.run_end);
          error_count++;
        end
      end
    end
  end

  // The receiver switches between steady popping, light and heavy random stalls,
  // and a fixed stall every eighth group of cycles.
  int pop_mode = 0;
  int pop_mode_left = 0;
  int pop_tick = 0;

  always @(posedge clk) begin
    pop_tick++;
    if (pop_mode_left == 0) begin
      pop_mode = $urandom_range(0, 3);
      pop_mode_left = $urandom_range(50, 300);
    end else begin
      pop_mode_left--;
    end
    case (pop_mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 3) != 0);
      2: pop <= ($urandom_range(0, 3) == 0);
      default: pop <= (pop_tick[5:3] != 3'd0);
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic signed [31:0] s, input logic l);
    bit taken;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    push <= 1'b1;
    item <= in_item_t'{sample: s, last: l};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] corner_sample();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return 32'h0000_0001;
      default: return 32'h0001_0000;
    endcase
  endfunction

  // Content styles: 0 full range, 1 narrow spread, 2 corner values, 3 flat.
  task automatic send_frame(input int len, input int style);
    logic signed [31:0] base;
    logic signed [31:0] s;
    base = $urandom;
    for (int k = 0; k < len; k++) begin
      case (style)
        0: s = $urandom;
        1: s = base + $urandom_range(0, 1023);
        2: s = corner_sample();
        default: s = base;
      endcase
      send_item(s, k == len - 1);
    end
  endtask

  task automatic test_single_sample();
    gaps_on = 1'b0;
    send_item(32'h8000_0000, 1'b1);
    send_item(32'h7fff_ffff, 1'b1);
    wait_drained();
  endtask

  task automatic test_flat_frame();
    gaps_on = 1'b1;
    send_item(32'hffff_ffff, 1'b0);
    send_item(32'hffff_ffff, 1'b0);
    send_item(32'hffff_ffff, 1'b1);
  endtask

  // Full-scale span: the offset reaches 2^32-1 before the shift.
  task automatic test_extreme_span();
    gaps_on = 1'b0;
    send_item(32'h0001_0000, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hffff_ffff, 1'b0);
    send_item(32'h7fff_ffff, 1'b0);
    send_item(32'h0000_0001, 1'b1);
  endtask

  task automatic test_small_frames();
    gaps_on = 1'b1;
    send_item(32'd5, 1'b0);
    send_item(32'd6, 1'b1);
    send_item(-32'sd3, 1'b0);
    send_item(-32'sd10, 1'b0);
    send_item(-32'sd7, 1'b1);
    send_item(32'h7fff_fffe, 1'b0);
    send_item(32'h7fff_ffff, 1'b1);
    wait_drained();
  endtask

  // Exactly full, last on a full store, and a frame that overruns the store.
  task automatic test_capacity();
    gaps_on = 1'b0;
    send_frame(FRAME_CAP, 0);
    gaps_on = 1'b1;
    send_frame(FRAME_CAP + 1, 1);
    send_frame(FRAME_CAP + 6, 0);
    wait_drained();
  endtask

  task automatic test_random_frames();
    int sent;
    int len;
    int pick;
    int style;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 49);
      if (pick == 0) len = $urandom_range(60, 70);
      else if (pick < 10) len = $urandom_range(9, 24);
      else len = $urandom_range(1, 8);
      pick = $urandom_range(0, 9);
      if (pick < 4) style = 0;
      else if (pick < 7) style = 1;
      else if (pick < 9) style = 2;
      else style = 3;
      gaps_on = ($urandom_range(0, 3) != 0);
      send_frame(len, style);
      sent += len;
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_sample();
    test_flat_frame();
    test_extreme_span();
    test_small_frames();
    test_capacity();
    test_random_frames();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

>>> min_max_normalize_top.f
sv/mmn_pkg.sv
sv/mmn_store.sv
sv/mmn_job_fifo.sv
sv/mmn_front.sv
sv/mmn_back.sv
sv/min_max_normalize_top.sv
test/tb.sv
